FILE: design/wtd_pkg.sv
// shared types, constants and digit arithmetic for the weather telegram decoder
`default_nettype none

package wtd_pkg;

	localparam int TELEGRAM_BYTES_DEF = 40;
	localparam int QUEUE_DEPTH_DEF    = 2;

	localparam logic [7:0] START_BYTE = 8'h57;
	localparam logic [7:0] YES_BYTE   = 8'h4A;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	localparam int IN_BITS  = 8;
	localparam int OUT_BITS = 80;

	// bytes and flags of one telegram that the record needs
	typedef struct packed {
		logic [7:0] temp_hund;
		logic [7:0] temp_ten;
		logic [7:0] temp_unit;
		logic [7:0] sun_tth;
		logic [7:0] sun_th;
		logic [7:0] day_hund;
		logic [7:0] day_ten;
		logic [7:0] day_unit;
		logic [7:0] wind_hund;
		logic [7:0] wind_ten;
		logic [7:0] wind_unit;
		logic       twilight;
		logic       rain;
	} frame_t;

	// unchecked digit value, -48..207
	function automatic logic signed [8:0] digit_of(input logic [7:0] b);
		return $signed({1'b0, b}) - $signed({1'b0, DIGIT_ZERO});
	endfunction

	function automatic logic [15:0] three_digits(input logic [7:0] h, input logic [7:0] t,
			input logic [7:0] u);
		logic signed [17:0] acc;
		acc = 18'(digit_of(h)) * 18'sd100 + 18'(digit_of(t)) * 18'sd10 + 18'(digit_of(u));
		return acc[15:0];
	endfunction

	function automatic logic [22:0] sunlight_of(input logic [7:0] tth, input logic [7:0] th);
		logic signed [23:0] acc;
		acc = 24'(digit_of(tth)) * 24'sd10000 + 24'(digit_of(th)) * 24'sd1000;
		return acc[22:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/wtd_front.sv
// front end: hunts for the start byte, tracks position and captures needed bytes
`default_nettype none

module wtd_front #(
	parameter int TELEGRAM_BYTES = wtd_pkg::TELEGRAM_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	output logic            push,
	input  logic            q_ready,
	output wtd_pkg::frame_t push_frame
);
	import wtd_pkg::*;

	localparam int PosW = $clog2(TELEGRAM_BYTES);
	localparam logic [PosW-1:0] LastPos = PosW'(TELEGRAM_BYTES - 1);

	logic            hunting_q;
	logic [PosW-1:0] pos_q;
	frame_t          frame_q;
	frame_t          frame_d;
	logic            at_last;
	logic            accept;
	logic            collect;

	assign at_last  = !hunting_q && (pos_q == LastPos);
	// only the closing byte needs room in the queue
	assign in_ready = !at_last || q_ready;
	assign accept   = in_valid && in_ready;
	assign collect  = accept && !hunting_q;
	assign push     = accept && at_last;

	always_comb begin
		frame_d = frame_q;
		unique case (pos_q)
			PosW'(2):  frame_d.temp_hund = in_byte;
			PosW'(3):  frame_d.temp_ten  = in_byte;
			PosW'(5):  frame_d.temp_unit = in_byte;
			PosW'(6):  frame_d.sun_tth   = in_byte;
			PosW'(7):  frame_d.sun_th    = in_byte;
			PosW'(12): frame_d.twilight  = (in_byte == YES_BYTE);
			PosW'(13): frame_d.day_hund  = in_byte;
			PosW'(14): frame_d.day_ten   = in_byte;
			PosW'(15): frame_d.day_unit  = in_byte;
			PosW'(16): frame_d.wind_hund = in_byte;
			PosW'(17): frame_d.wind_ten  = in_byte;
			PosW'(19): frame_d.wind_unit = in_byte;
			PosW'(20): frame_d.rain      = (in_byte == YES_BYTE);
			default:   frame_d = frame_q;
		endcase
	end

	// closing byte may itself be a captured one, so push the updated frame
	assign push_frame = frame_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunting_q <= 1'b1;
			pos_q     <= '0;
		end else if (accept) begin
			if (hunting_q) begin
				if (in_byte == START_BYTE) begin
					hunting_q <= 1'b0;
					pos_q     <= PosW'(1);
				end
			end else if (at_last) begin
				hunting_q <= 1'b1;
				pos_q     <= '0;
			end else begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (collect) begin
			frame_q <= frame_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/wtd_queue.sv
// short queue of captured telegrams between front and back
`default_nettype none

module wtd_queue #(
	parameter int DEPTH = wtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  wtd_pkg::frame_t push_frame,
	output logic            head_valid,
	input  logic            pop,
	output wtd_pkg::frame_t head_frame
);
	import wtd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

	frame_t          entry_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_frame = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

`default_nettype wire

FILE: design/wtd_back.sv
// back end: turns a captured telegram into the record and holds it for the receiver
`default_nettype none

module wtd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  wtd_pkg::frame_t              head_frame,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [wtd_pkg::OUT_BITS-1:0] out_data
);
	import wtd_pkg::*;

	logic                tvalid_q;
	logic [OUT_BITS-1:0] tdata_q;
	logic [OUT_BITS-1:0] record;

	// temperature, sunlight, twilight, daylight, wind, rain from bit 0 up
	always_comb begin
		record = '0;
		record[15:0]  = three_digits(head_frame.temp_hund, head_frame.temp_ten,
				head_frame.temp_unit);
		record[38:16] = sunlight_of(head_frame.sun_tth, head_frame.sun_th);
		record[39]    = head_frame.twilight;
		record[55:40] = three_digits(head_frame.day_hund, head_frame.day_ten,
				head_frame.day_unit);
		record[71:56] = three_digits(head_frame.wind_hund, head_frame.wind_ten,
				head_frame.wind_unit);
		record[72]    = head_frame.rain;
	end

	assign pop       = head_valid && (!tvalid_q || out_ready);
	assign out_valid = tvalid_q;
	assign out_data  = tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (pop) begin
			tvalid_q <= 1'b1;
		end else if (out_ready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= record;
		end
	end

endmodule

`default_nettype wire

FILE: design/weather_telegram_decoder.sv
// Weather telegram decoder, top level.
// Slave stream carries one received serial byte per transaction in s_axis_tdata.
// Bytes are dropped until an ASCII 'W'; that byte opens a telegram of
// TELEGRAM_BYTES bytes, and when the last one is taken one record goes out
// on the master stream, then the block hunts again.
// Throughput: one byte per cycle. The slave side only stalls on the closing byte
// of a telegram while the telegram queue (QUEUE_DEPTH entries) is full.
// The closing byte's transaction writes the queue; the record then loads into the
// output register and is valid on m_axis once that register is free.
// The output register lets the next record load in the same cycle the current
// one is taken; while the receiver stalls, records pile up in the queue and
// bytes keep flowing until a closing byte finds it full.
// Reset (arst_n low) puts the block in hunting mode and empties queue and
// output register; captured bytes are not cleared and need not be.
`default_nettype none

module weather_telegram_decoder #(
	parameter int TELEGRAM_BYTES = wtd_pkg::TELEGRAM_BYTES_DEF,
	parameter int QUEUE_DEPTH    = wtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [wtd_pkg::IN_BITS-1:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] temperature_tenths, [38:16] sunlight_lux, [39] twilight_flag,
	// [55:40] daylight_level, [71:56] wind_tenths, [72] rain_flag, [79:73] zero
	output logic [wtd_pkg::OUT_BITS-1:0] m_axis_tdata
);
	import wtd_pkg::*;

	logic   push;
	logic   push_ready;
	frame_t push_frame;
	logic   head_valid;
	logic   pop;
	frame_t head_frame;

	wtd_front #(
		.TELEGRAM_BYTES(TELEGRAM_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.push      (push),
		.q_ready   (push_ready),
		.push_frame(push_frame)
	);

	wtd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_frame(push_frame),
		.head_valid(head_valid),
		.pop       (pop),
		.head_frame(head_frame)
	);

	wtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_frame(head_frame),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench for the weather telegram decoder: directed and random byte streams
`timescale 1ns / 1ps

module testbench;
	import wtd_pkg::*;

	localparam int TG_BYTES     = TELEGRAM_BYTES_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_BYTES = 900;

	// byte positions read by the record
	localparam int POS_TEMP_HUND = 2;
	localparam int POS_TEMP_TEN  = 3;
	localparam int POS_TEMP_UNIT = 5;
	localparam int POS_SUN_TTH   = 6;
	localparam int POS_SUN_TH    = 7;
	localparam int POS_TWILIGHT  = 12;
	localparam int POS_DAY_HUND  = 13;
	localparam int POS_DAY_TEN   = 14;
	localparam int POS_DAY_UNIT  = 15;
	localparam int POS_WIND_HUND = 16;
	localparam int POS_WIND_TEN  = 17;
	localparam int POS_WIND_UNIT = 19;
	localparam int POS_RAIN      = 20;

	typedef enum {FILL_DIGITS, FILL_RANDOM} telegram_fill_t;

	typedef struct {
		logic signed [15:0] temperature;
		logic signed [22:0] sunlight;
		logic               twilight;
		logic signed [15:0] daylight;
		logic signed [15:0] wind;
		logic               rain;
	} wx_record_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic [IN_BITS-1:0]  s_tdata = '0;
	logic                m_tready = 1'b0;
	wire                 s_axis_tready;
	wire                 m_axis_tvalid;
	wire  [OUT_BITS-1:0] m_axis_tdata;

	// decoder shadow state
	logic [7:0]  frame_bytes [TG_BYTES];
	bit          collecting = 1'b0;
	int          fill_pos = 0;
	wx_record_t  pending_records [$];
	wx_record_t  want_rec;

	int errors = 0;
	int records_seen = 0;
	int telegram_bytes = 0;
	int hunted_bytes = 0;
	int cycles = 0;

	bit sender_gaps = 1'b0;
	bit rx_stalls = 1'b0;
	int hold_request = 0;
	int stall_left = 0;

	weather_telegram_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("%0t timeout after %0d cycles", $time, cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic int digit_at(input int pos);
		return int'(frame_bytes[pos]) - int'(DIGIT_ZERO);
	endfunction

	function automatic wx_record_t decode_frame();
		wx_record_t r;
		r.temperature = 16'(digit_at(POS_TEMP_HUND) * 100 + digit_at(POS_TEMP_TEN) * 10
			+ digit_at(POS_TEMP_UNIT));
		r.sunlight = 23'(digit_at(POS_SUN_TTH) * 10000 + digit_at(POS_SUN_TH) * 1000);
		r.twilight = (frame_bytes[POS_TWILIGHT] == YES_BYTE);
		r.daylight = 16'(digit_at(POS_DAY_HUND) * 100 + digit_at(POS_DAY_TEN) * 10
			+ digit_at(POS_DAY_UNIT));
		r.wind = 16'(digit_at(POS_WIND_HUND) * 100 + digit_at(POS_WIND_TEN) * 10
			+ digit_at(POS_WIND_UNIT));
		r.rain = (frame_bytes[POS_RAIN] == YES_BYTE);
		return r;
	endfunction

	// returns 1 when the byte went into a telegram, 0 when dropped while hunting
	function automatic bit absorb_rx_byte(input logic [7:0] b);
		if (!collecting) begin
			if (b != START_BYTE)
				return 1'b0;
			collecting = 1'b1;
			fill_pos = 0;
		end
		frame_bytes[fill_pos] = b;
		fill_pos++;
		if (fill_pos == TG_BYTES) begin
			pending_records.push_back(decode_frame());
			collecting = 1'b0;
			fill_pos = 0;
		end
		return 1'b1;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!sender_gaps || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit is_digit_pos(input int p);
		return p inside {POS_TEMP_HUND, POS_TEMP_TEN, POS_TEMP_UNIT, POS_SUN_TTH, POS_SUN_TH,
			POS_DAY_HUND, POS_DAY_TEN, POS_DAY_UNIT, POS_WIND_HUND, POS_WIND_TEN,
			POS_WIND_UNIT};
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		if (absorb_rx_byte(b))
			telegram_bytes++;
		else
			hunted_bytes++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() != 0)
			@(posedge clk);
	endtask

	// start byte followed by len-1 body bytes
	task automatic send_telegram(input telegram_fill_t fill, input int len);
		logic [7:0] b;
		send_byte(START_BYTE);
		for (int p = 1; p < len; p++) begin
			if (fill == FILL_RANDOM)
				b = 8'($urandom_range(0, 255));
			else if (is_digit_pos(p))
				b = ($urandom_range(0, 9) != 0) ? 8'(DIGIT_ZERO + $urandom_range(0, 9))
					: 8'($urandom_range(0, 255));
			else if (p == POS_TWILIGHT || p == POS_RAIN)
				b = ($urandom_range(0, 2) != 0) ? (($urandom_range(0, 1) != 0) ? YES_BYTE
					: 8'h4E) : 8'($urandom_range(0, 255));
			else
				b = 8'($urandom_range(0, 255));
			send_byte(b);
		end
	endtask

	task automatic send_uniform_telegram(input logic [7:0] fill, input logic [7:0] flag_byte);
		send_byte(START_BYTE);
		for (int p = 1; p < TG_BYTES; p++)
			send_byte((p == POS_TWILIGHT || p == POS_RAIN) ? flag_byte : fill);
	endtask

	// receiver side: random stalls plus requested long hold-offs
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (hold_request > 0) begin
				m_tready <= 1'b0;
				stall_left = hold_request - 1;
				hold_request = 0;
			end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
				m_tready <= 1'b0;
				stall_left = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
					: $urandom_range(10, 60);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_tready) begin
			if (pending_records.size() == 0) begin
				errors++;
				$display("%0t unexpected record expected none actual %h", $time, m_axis_tdata);
			end else begin
				want_rec = pending_records.pop_front();
				records_seen++;
				check_field("temperature_tenths", want_rec.temperature,
					$signed(m_axis_tdata[15:0]));
				check_field("sunlight_lux", want_rec.sunlight, $signed(m_axis_tdata[38:16]));
				check_field("twilight_flag", want_rec.twilight, m_axis_tdata[39]);
				check_field("daylight_level", want_rec.daylight, $signed(m_axis_tdata[55:40]));
				check_field("wind_tenths", want_rec.wind, $signed(m_axis_tdata[71:56]));
				check_field("rain_flag", want_rec.rain, m_axis_tdata[72]);
				check_field("pad bits", 0, m_axis_tdata[79:73]);
			end
		end
	end

	// field extremes, flags, and bytes dropped while hunting
	task automatic test_extremes();
		sender_gaps = 1'b0;
		rx_stalls = 1'b0;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(YES_BYTE);
		send_byte(8'h56);
		send_byte(8'h58);
		send_uniform_telegram(DIGIT_ZERO, YES_BYTE);
		send_uniform_telegram(8'h00, 8'h00);
		send_uniform_telegram(8'hFF, 8'hFF);
		send_uniform_telegram(8'h39, YES_BYTE);
		send_uniform_telegram(YES_BYTE, YES_BYTE);
		wait_drained();
	endtask

	// a start byte inside a telegram is plain data
	task automatic test_start_inside_telegram();
		sender_gaps = 1'b1;
		rx_stalls = 1'b1;
		send_uniform_telegram(START_BYTE, START_BYTE);
		send_telegram(FILL_DIGITS, 17);
		send_telegram(FILL_DIGITS, TG_BYTES);
		send_telegram(FILL_DIGITS, TG_BYTES);
		wait_drained();
	endtask

	// long receiver hold-off so the record queue fills and the input stalls
	task automatic test_backpressure();
		sender_gaps = 1'b0;
		rx_stalls = 1'b0;
		hold_request = 500;
		repeat (5) send_telegram(FILL_DIGITS, TG_BYTES);
		wait_drained();
		rx_stalls = 1'b1;
		hold_request = 300;
		repeat (4) send_telegram(FILL_RANDOM, TG_BYTES);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int kind;
		int start_bytes;
		start_bytes = telegram_bytes;
		while (telegram_bytes - start_bytes < RANDOM_BYTES) begin
			sender_gaps = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			kind = $urandom_range(0, 99);
			if (kind < 65)
				send_telegram(FILL_DIGITS, TG_BYTES);
			else if (kind < 80)
				send_telegram(FILL_RANDOM, TG_BYTES);
			else if (kind < 90)
				send_telegram(FILL_DIGITS, $urandom_range(1, TG_BYTES - 1));
			else
				repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
		end
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_start_inside_telegram();
		test_backpressure();
		test_random_traffic();
		repeat (20) @(posedge clk);
		$display("covered %0d telegram bytes and %0d bytes dropped while hunting",
			telegram_bytes, hunted_bytes);
		$display("checked %0d records, %0d field errors", records_seen, errors);
		if (errors == 0 && pending_records.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: weather_telegram_decoder.f
design/wtd_pkg.sv
design/wtd_front.sv
design/wtd_queue.sv
design/wtd_back.sv
design/weather_telegram_decoder.sv
sim/testbench.sv
